[src/ihq_pkg.sv]
package ihq_pkg;

    // Operation codes carried by a request
    localparam logic [1:0] OP_INSERT     = 2'd0;
    localparam logic [1:0] OP_DELETE_MIN = 2'd1;
    localparam logic [1:0] OP_DECREASE   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_NODE    = 3'd3;
    localparam logic [2:0] ST_RAISED  = 3'd4;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_READ_FIRST,
        CMD_DECODE,
        CMD_DK_READ,
        CMD_DK_CHECK,
        CMD_UP_READ,
        CMD_UP_STEP,
        CMD_DN_READ,
        CMD_DN_STEP,
        CMD_PLACE,
        CMD_FINISH
    } dp_cmd_t;

    // Datapath status back to the controller
    typedef struct packed {
        logic clear_last;
        logic dec_up;
        logic dec_down;
        logic dec_dk;
        logic dk_raise;
        logic up_more;
        logic up_move;
        logic dn_more;
        logic dn_move;
        logic rsp_busy;
    } dp_stat_t;

endpackage

[src/ihq_ctrl.sv]
module ihq_ctrl
    import ihq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     ready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECODE,
        S_DK_RD,
        S_DK_CHK,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_PLACE,
        S_DONE
    } state_t;

    state_t state_reg;

    always_comb
    begin
        case (state_reg)
            S_CLEAR:  cmd = CMD_CLEAR;
            S_IDLE:   cmd = req_valid ? CMD_LOAD : CMD_NONE;
            S_READ:   cmd = CMD_READ_FIRST;
            S_DECODE: cmd = CMD_DECODE;
            S_DK_RD:  cmd = CMD_DK_READ;
            S_DK_CHK: cmd = CMD_DK_CHECK;
            S_UP_RD:  cmd = CMD_UP_READ;
            S_UP_CMP: cmd = CMD_UP_STEP;
            S_DN_RD:  cmd = CMD_DN_READ;
            S_DN_CMP: cmd = CMD_DN_STEP;
            S_PLACE:  cmd = CMD_PLACE;
            S_DONE:   cmd = stat.rsp_busy ? CMD_NONE : CMD_FINISH;
            default:  cmd = CMD_NONE;
        endcase
    end

    assign ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:  if (stat.clear_last) state_reg <= S_IDLE;
                S_IDLE:   if (req_valid) state_reg <= S_READ;
                S_READ:   state_reg <= S_DECODE;
                S_DECODE:
                begin
                    if (stat.dec_up)
                        state_reg <= S_UP_RD;
                    else if (stat.dec_down)
                        state_reg <= S_DN_RD;
                    else if (stat.dec_dk)
                        state_reg <= S_DK_RD;
                    else
                        state_reg <= S_DONE;
                end
                S_DK_RD:  state_reg <= S_DK_CHK;
                S_DK_CHK: state_reg <= stat.dk_raise ? S_DONE : S_UP_RD;
                S_UP_RD:  state_reg <= stat.up_more ? S_UP_CMP : S_PLACE;
                S_UP_CMP: state_reg <= stat.up_move ? S_UP_RD : S_PLACE;
                S_DN_RD:  state_reg <= stat.dn_more ? S_DN_CMP : S_PLACE;
                S_DN_CMP: state_reg <= stat.dn_move ? S_DN_RD : S_PLACE;
                S_PLACE:  state_reg <= S_DONE;
                S_DONE:   if (!stat.rsp_busy) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[src/ihq_datapath.sv]
module ihq_datapath
    import ihq_pkg::*;
#(
    parameter int CAPACITY      = 256,
    parameter int NODE_COUNT    = 1024,
    parameter int PRIORITY_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic [1:0]  op,
    input  logic [9:0]  node_id,
    input  logic [15:0] priority_req,
    input  logic        rsp_stall,
    output logic        rsp_valid,
    output logic [2:0]  status,
    output logic [9:0]  result_node,
    output logic [15:0] result_priority,
    output logic [8:0]  entry_count
);

    localparam int SLOT_W = $clog2(CAPACITY + 1);
    localparam int NODE_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int PB     = PRIORITY_BITS;
    localparam int SLOTS  = CAPACITY + 1;

    // heap slots, 1-based; position map cleared by a sweep after reset
    logic [NODE_W-1:0] slot_node_mem [SLOTS];
    logic [PB-1:0]     slot_prio_mem [SLOTS];
    logic [SLOT_W-1:0] pos_mem       [NODE_COUNT];

    logic [1:0]        op_reg;
    logic [NODE_W-1:0] node_idx_reg;
    logic              node_ok_reg;
    logic [PB-1:0]     prio_reg;
    logic [SLOT_W-1:0] size_reg;
    logic [SLOT_W-1:0] hole_reg;
    logic [NODE_W-1:0] cur_node_reg;
    logic [PB-1:0]     cur_prio_reg;
    logic [2:0]        res_status_reg;
    logic [NODE_W-1:0] res_node_reg;
    logic [PB-1:0]     res_prio_reg;
    logic [NODE_W-1:0] clr_reg;
    logic              rsp_valid_reg;
    logic [2:0]        status_reg;
    logic [9:0]        result_node_reg;
    logic [15:0]       result_prio_reg;
    logic [8:0]        count_reg;

    logic [NODE_W-1:0] node_a_reg, node_b_reg;
    logic [PB-1:0]     prio_a_reg, prio_b_reg;
    logic [SLOT_W-1:0] pos_rd_reg;

    logic [SLOT_W:0]   kid_w;
    logic [SLOT_W-1:0] kid, kid_r, kid_sel, parent;
    logic              take_right;
    logic [NODE_W-1:0] kid_node;
    logic [PB-1:0]     kid_prio;
    logic [SLOT_W-1:0] rd_a, rd_b;
    logic              ins_ok, dk_ok;

    logic              slot_we;
    logic [SLOT_W-1:0] slot_wa;
    logic [NODE_W-1:0] slot_wn;
    logic [PB-1:0]     slot_wp;
    logic              pos_we;
    logic [NODE_W-1:0] pos_wa;
    logic [SLOT_W-1:0] pos_wd;

    assign kid_w      = {hole_reg, 1'b0};
    assign kid        = kid_w[SLOT_W-1:0];
    assign kid_r      = (kid == size_reg) ? kid : kid + 1'b1;
    assign take_right = (kid != size_reg) && (prio_a_reg > prio_b_reg);
    assign kid_sel    = take_right ? kid_r : kid;
    assign kid_node   = take_right ? node_b_reg : node_a_reg;
    assign kid_prio   = take_right ? prio_b_reg : prio_a_reg;
    assign parent     = hole_reg >> 1;

    assign ins_ok = node_ok_reg && (pos_rd_reg == '0) && (size_reg < SLOT_W'(CAPACITY));
    assign dk_ok  = node_ok_reg && (pos_rd_reg != '0) && (pos_rd_reg <= size_reg);

    always_comb
    begin
        stat            = '0;
        stat.clear_last = (clr_reg == NODE_W'(NODE_COUNT - 1));
        stat.dec_up     = (op_reg == OP_INSERT) && ins_ok;
        stat.dec_down   = (op_reg == OP_DELETE_MIN) && (size_reg > SLOT_W'(1));
        stat.dec_dk     = (op_reg == OP_DECREASE) && dk_ok;
        stat.dk_raise   = prio_reg > prio_a_reg;
        stat.up_more    = hole_reg > SLOT_W'(1);
        stat.up_move    = prio_a_reg > cur_prio_reg;
        stat.dn_more    = kid_w <= {1'b0, size_reg};
        stat.dn_move    = kid_prio < cur_prio_reg;
        stat.rsp_busy   = rsp_valid_reg && rsp_stall;
    end

    // read addresses
    always_comb
    begin
        case (cmd)
            CMD_READ_FIRST: rd_a = SLOT_W'(1);
            CMD_UP_READ:    rd_a = parent;
            CMD_DN_READ:    rd_a = kid;
            default:        rd_a = hole_reg;
        endcase
        rd_b = (cmd == CMD_DN_READ) ? kid_r : size_reg;
    end

    // write ports
    always_comb
    begin
        slot_we = 1'b0;
        slot_wa = hole_reg;
        slot_wn = cur_node_reg;
        slot_wp = cur_prio_reg;
        pos_we  = 1'b0;
        pos_wa  = cur_node_reg;
        pos_wd  = hole_reg;
        case (cmd)
            CMD_CLEAR:
            begin
                pos_we = 1'b1;
                pos_wa = clr_reg;
                pos_wd = '0;
            end
            CMD_DECODE:
            begin
                pos_we = (op_reg == OP_DELETE_MIN) && (size_reg != '0);
                pos_wa = node_a_reg;
                pos_wd = '0;
            end
            CMD_UP_STEP:
            begin
                slot_we = stat.up_move;
                slot_wn = node_a_reg;
                slot_wp = prio_a_reg;
                pos_we  = stat.up_move;
                pos_wa  = node_a_reg;
            end
            CMD_DN_STEP:
            begin
                slot_we = stat.dn_move;
                slot_wn = kid_node;
                slot_wp = kid_prio;
                pos_we  = stat.dn_move;
                pos_wa  = kid_node;
            end
            CMD_PLACE:
            begin
                slot_we = 1'b1;
                pos_we  = 1'b1;
            end
            default:
            begin
                slot_we = 1'b0;
                pos_we  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_node_mem[slot_wa] <= slot_wn;
            slot_prio_mem[slot_wa] <= slot_wp;
        end
        node_a_reg <= slot_node_mem[rd_a];
        prio_a_reg <= slot_prio_mem[rd_a];
        node_b_reg <= slot_node_mem[rd_b];
        prio_b_reg <= slot_prio_mem[rd_b];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
            pos_mem[pos_wa] <= pos_wd;
        pos_rd_reg <= pos_mem[node_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg      <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd == CMD_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cmd == CMD_DECODE)
            begin
                if (stat.dec_up)
                    size_reg <= size_reg + 1'b1;
                else if ((op_reg == OP_DELETE_MIN) && (size_reg != '0))
                    size_reg <= size_reg - 1'b1;
            end
            if (cmd == CMD_FINISH)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd)
            CMD_LOAD:
            begin
                op_reg         <= op;
                node_idx_reg   <= NODE_W'(node_id);
                node_ok_reg    <= (32'(node_id) < NODE_COUNT);
                prio_reg       <= PB'(priority_req);
                res_status_reg <= ST_OK;
                res_node_reg   <= '0;
                res_prio_reg   <= '0;
            end
            CMD_DECODE:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (!node_ok_reg || (pos_rd_reg != '0))
                            res_status_reg <= ST_NODE;
                        else if (!ins_ok)
                            res_status_reg <= ST_FULL;
                        hole_reg     <= size_reg + 1'b1;
                        cur_node_reg <= node_idx_reg;
                        cur_prio_reg <= prio_reg;
                    end
                    OP_DELETE_MIN:
                    begin
                        if (size_reg == '0)
                            res_status_reg <= ST_EMPTY;
                        else
                        begin
                            res_node_reg <= node_a_reg;
                            res_prio_reg <= prio_a_reg;
                        end
                        hole_reg     <= SLOT_W'(1);
                        cur_node_reg <= node_b_reg;
                        cur_prio_reg <= prio_b_reg;
                    end
                    OP_DECREASE:
                    begin
                        if (!dk_ok)
                            res_status_reg <= ST_NODE;
                        hole_reg <= pos_rd_reg;
                    end
                    default: res_status_reg <= ST_OK;
                endcase
            end
            CMD_DK_CHECK:
            begin
                if (stat.dk_raise)
                    res_status_reg <= ST_RAISED;
                cur_node_reg <= node_idx_reg;
                cur_prio_reg <= prio_reg;
            end
            CMD_UP_STEP:
                if (stat.up_move)
                    hole_reg <= parent;
            CMD_DN_STEP:
                if (stat.dn_move)
                    hole_reg <= kid_sel;
            CMD_FINISH:
            begin
                status_reg      <= res_status_reg;
                result_node_reg <= 10'(res_node_reg);
                result_prio_reg <= 16'(res_prio_reg);
                count_reg       <= 9'(size_reg);
            end
            default:
            begin
                hole_reg <= hole_reg;
            end
        endcase
    end

    assign rsp_valid       = rsp_valid_reg;
    assign status          = status_reg;
    assign result_node     = result_node_reg;
    assign result_priority = result_prio_reg;
    assign entry_count     = count_reg;

endmodule

[src/indexed_min_heap_queue_core.sv]
// Operation: a request is loaded, read and decoded; insert then sifts up, delete-min sifts down and
// decrease-key reads and checks the entry before sifting up; the moved entry is then placed.
// Requests: one at a time, the next taken once the result appears; each sift level is a
// read + compare.
// Reset: asynchronous, active low. The position map is then cleared by a sweep over all NODE_COUNT
// entries (1024 by default) during which requests are stalled.
module indexed_min_heap_queue_core
    import ihq_pkg::*;
#(
    parameter int CAPACITY      = 256,
    parameter int NODE_COUNT    = 1024,
    parameter int PRIORITY_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request channel
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  op,
    input  logic [9:0]  node_id,
    input  logic [15:0] priority_req,
    // result channel, registered; a new request may be taken while it waits
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [9:0]  result_node,
    output logic [15:0] result_priority,
    output logic [8:0]  entry_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     ready;

    // Controller sequences: clear sweep, request decode, decrease-key check, sift up / sift down loops,
    // final placement, and hand-off to the result register.
    ihq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .stat      (stat),
        .cmd       (cmd),
        .ready     (ready)
    );

    assign req_stall = !ready;

    // Datapath holds the slot memories (two read ports for the children during
    // sift down), the position map and the result register.
    ihq_datapath #(
        .CAPACITY      (CAPACITY),
        .NODE_COUNT    (NODE_COUNT),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .op              (op),
        .node_id         (node_id),
        .priority_req    (priority_req),
        .rsp_stall       (rsp_stall),
        .rsp_valid       (rsp_valid),
        .status          (status),
        .result_node     (result_node),
        .result_priority (result_priority),
        .entry_count     (entry_count)
    );

endmodule

[src/ihq_checker.sv]
module ihq_checker
    import ihq_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [2:0]  status,
    input logic [9:0]  result_node,
    input logic [15:0] result_priority,
    input logic [8:0]  entry_count
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(entry_count))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> entry_count == 9'(CAPACITY))
        else $error("full status with heap not at capacity");

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_EMPTY) |-> entry_count == '0)
        else $error("empty status with entries present");

    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (result_node == '0) && (result_priority == '0))
        else $error("removed entry reported on a failed request");

endmodule

bind indexed_min_heap_queue_core ihq_checker #(.CAPACITY(CAPACITY)) u_chk (.*);
